FILE: design/nva_pkg.sv
package nva_pkg;

  localparam int VIDX_W       = 10;
  localparam int NORM_W       = 16;
  localparam int SUM_W        = 32;
  localparam int CNT_W        = 16;
  localparam int STORE_LIMIT  = 1024;
  localparam int MAX_VERTICES_DEF = 1024;
  localparam int MAX_FACES_DEF    = 65535;

  typedef enum logic {
    OP_ADD  = 1'b0,
    OP_READ = 1'b1
  } op_t;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_RD,
    ST_WR,
    ST_DIV,
    ST_EMIT
  } state_t;

  typedef struct packed {
    logic signed [SUM_W-1:0] sum_x;
    logic signed [SUM_W-1:0] sum_y;
    logic signed [SUM_W-1:0] sum_z;
    logic [CNT_W-1:0]        count;
  } entry_t;

  typedef struct packed {
    logic [VIDX_W-1:0] vertex_id;
    logic [CNT_W-1:0]  count;
    logic              empty;
  } res_info_t;

endpackage

FILE: design/nva_store.sv
module nva_store
  import nva_pkg::*;
#(
  parameter int DEPTH = STORE_LIMIT,
  parameter int AW    = 10
) (
  input  logic          clk,
  input  logic          en,
  input  logic          we,
  input  logic [AW-1:0] addr,
  input  entry_t        wdata,
  output entry_t        rdata
);

  entry_t mem [DEPTH];

  always_ff @(posedge clk) begin
    if (en) begin
      if (we) begin
        mem[addr] <= wdata;
      end else begin
        rdata <= mem[addr];
      end
    end
  end

endmodule

FILE: design/nva_div_lane.sv
module nva_div_lane
  import nva_pkg::*;
(
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     start,
  input  logic signed [SUM_W-1:0]  dividend,
  input  logic [CNT_W-1:0]         divisor,
  output logic                     done,
  output logic signed [NORM_W-1:0] quotient
);

  logic [SUM_W-1:0] qreg;
  logic [CNT_W-1:0] rem;
  logic [CNT_W-1:0] dvs;
  logic             neg;
  logic             busy;
  logic [4:0]       step;
  logic [CNT_W:0]   trial;
  logic             fits;

  // One restoring step per cycle on the magnitude of the dividend.
  assign trial = {rem, qreg[SUM_W-1]};
  assign fits  = trial >= {1'b0, dvs};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      step <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        step <= '0;
        neg  <= dividend[SUM_W-1];
        qreg <= dividend[SUM_W-1] ? (~dividend + 1'b1) : dividend;
        rem  <= '0;
        dvs  <= divisor;
      end else if (busy) begin
        rem  <= fits ? CNT_W'(trial - {1'b0, dvs}) : trial[CNT_W-1:0];
        qreg <= {qreg[SUM_W-2:0], fits};
        step <= step + 1'b1;
        if (step == 5'd31) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  assign quotient = neg ? NORM_W'(~qreg + 1'b1) : qreg[NORM_W-1:0];

endmodule

FILE: design/nva_merge.sv
module nva_merge
  import nva_pkg::*;
(
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     load,
  input  res_info_t                info,
  input  logic signed [NORM_W-1:0] qx,
  input  logic signed [NORM_W-1:0] qy,
  input  logic signed [NORM_W-1:0] qz,
  output logic                     ready,
  output logic                     out_valid,
  input  logic                     out_stall,
  output logic [VIDX_W-1:0]        vertex_id,
  output logic signed [NORM_W-1:0] avg_x,
  output logic signed [NORM_W-1:0] avg_y,
  output logic signed [NORM_W-1:0] avg_z,
  output logic [CNT_W-1:0]         face_count,
  output logic                     empty_res
);

  assign ready = !out_valid || !out_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (ready) begin
      out_valid <= load;
    end
  end

  // An empty vertex gives a zero normal whatever the lanes hold.
  always_ff @(posedge clk) begin
    if (load && ready) begin
      vertex_id  <= info.vertex_id;
      face_count <= info.count;
      empty_res  <= info.empty;
      avg_x      <= info.empty ? '0 : qx;
      avg_y      <= info.empty ? '0 : qy;
      avg_z      <= info.empty ? '0 : qz;
    end
  end

endmodule

FILE: design/vertex_normal_averager_unit.sv
// Channel | handshake            | beat carries
// in      | in_valid / in_stall  | opcode, vertex_a..c, normal_x..z
// out     | out_valid / out_stall| vertex_id, avg_x..z, face_count, empty_res
//
// An add-face beat takes its accept step, then a store read and, unless the count
// is saturated, a write for each distinct in-range vertex; others are skipped.
// A read with faces runs accept, read, write-back of zero, the 32-step division
// in three lanes, emit; an empty vertex skips the division, an out-of-range one
// skips the store too. Reset clears the store one entry a cycle (MAX_VERTICES
// entries, capped at 1024) with in_stall high; a stalled output holds a read at emit.
module vertex_normal_averager_unit
  import nva_pkg::*;
#(
  parameter int MAX_VERTICES = MAX_VERTICES_DEF,
  parameter int MAX_FACES    = MAX_FACES_DEF
) (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     in_valid,
  output logic                     in_stall,
  input  logic                     opcode,
  input  logic [VIDX_W-1:0]        vertex_a,
  input  logic [VIDX_W-1:0]        vertex_b,
  input  logic [VIDX_W-1:0]        vertex_c,
  input  logic signed [NORM_W-1:0] normal_x,
  input  logic signed [NORM_W-1:0] normal_y,
  input  logic signed [NORM_W-1:0] normal_z,
  output logic                     out_valid,
  input  logic                     out_stall,
  output logic [VIDX_W-1:0]        vertex_id,
  output logic signed [NORM_W-1:0] avg_x,
  output logic signed [NORM_W-1:0] avg_y,
  output logic signed [NORM_W-1:0] avg_z,
  output logic [CNT_W-1:0]         face_count,
  output logic                     empty_res
);

  localparam int DEPTH = (MAX_VERTICES > STORE_LIMIT) ? STORE_LIMIT : MAX_VERTICES;
  localparam int AW    = $clog2(DEPTH);

  state_t state, state_next;

  // Latched beat and per-beat state.
  op_t                     op;
  logic [VIDX_W-1:0]       va, vb, vc;
  logic signed [NORM_W-1:0] nx, ny, nz;
  logic [1:0]              k;
  logic [AW-1:0]           clr_addr;
  logic [CNT_W-1:0]        res_count;
  logic                    res_empty;

  logic [VIDX_W-1:0] cur;
  logic              cur_ok;
  logic              cur_en;
  logic              last_k;
  logic              sat;

  logic          mem_en, mem_we;
  logic [AW-1:0] mem_addr;
  entry_t        mem_wdata, mem_rdata;

  logic      div_start;
  logic      div_done_x, div_done_y, div_done_z;
  logic signed [NORM_W-1:0] qx, qy, qz;
  logic      merge_load, merge_ready;
  res_info_t info;

  logic accept;
  assign accept   = in_valid && !in_stall;
  assign in_stall = (state != ST_IDLE);

  always_comb begin
    case (k)
      2'd0:    cur = va;
      2'd1:    cur = vb;
      default: cur = vc;
    endcase
  end

  assign cur_ok = ({7'b0, cur} < 17'(MAX_VERTICES));

  // A vertex repeated within one face is taken only at its first mention.
  always_comb begin
    case (k)
      2'd0:    cur_en = cur_ok;
      2'd1:    cur_en = cur_ok && (vb != va);
      default: cur_en = cur_ok && (vc != va) && (vc != vb);
    endcase
  end

  assign last_k = (k == 2'd2) || (op == OP_READ);
  assign sat    = (mem_rdata.count >= CNT_W'(MAX_FACES));

  // Next state.
  always_comb begin
    state_next = state;
    case (state)
      ST_CLEAR: if (clr_addr == AW'(DEPTH - 1)) state_next = ST_IDLE;
      ST_IDLE:  if (accept) state_next = ST_RD;
      ST_RD: begin
        if (cur_en) begin
          state_next = ST_WR;
        end else if (op == OP_READ) begin
          state_next = ST_EMIT;
        end else if (last_k) begin
          state_next = ST_IDLE;
        end
      end
      ST_WR: begin
        if (op == OP_READ) begin
          state_next = (mem_rdata.count == '0) ? ST_EMIT : ST_DIV;
        end else begin
          state_next = last_k ? ST_IDLE : ST_RD;
        end
      end
      ST_DIV:  if (div_done_x) state_next = ST_EMIT;
      ST_EMIT: if (merge_ready) state_next = ST_IDLE;
      default: state_next = ST_IDLE;
    endcase
  end

  // Store and lane control.
  always_comb begin
    mem_en     = 1'b0;
    mem_we     = 1'b0;
    mem_addr   = cur[AW-1:0];
    mem_wdata  = '0;
    div_start  = 1'b0;
    merge_load = 1'b0;
    case (state)
      ST_CLEAR: begin
        mem_en   = 1'b1;
        mem_we   = 1'b1;
        mem_addr = clr_addr;
      end
      ST_RD: mem_en = cur_en;
      ST_WR: begin
        if (op == OP_READ) begin
          mem_en    = 1'b1;
          mem_we    = 1'b1;
          div_start = (mem_rdata.count != '0);
        end else begin
          mem_en          = !sat;
          mem_we          = !sat;
          mem_wdata.sum_x = mem_rdata.sum_x + SUM_W'(nx);
          mem_wdata.sum_y = mem_rdata.sum_y + SUM_W'(ny);
          mem_wdata.sum_z = mem_rdata.sum_z + SUM_W'(nz);
          mem_wdata.count = mem_rdata.count + 1'b1;
        end
      end
      ST_EMIT: merge_load = 1'b1;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= ST_CLEAR;
      clr_addr <= '0;
      k        <= '0;
    end else begin
      state <= state_next;
      if (state == ST_CLEAR) clr_addr <= clr_addr + 1'b1;
      if (accept) begin
        k <= '0;
      end else if ((state == ST_RD && !cur_en) || (state == ST_WR)) begin
        k <= k + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      op <= op_t'(opcode);
      va <= vertex_a;
      vb <= vertex_b;
      vc <= vertex_c;
      nx <= normal_x;
      ny <= normal_y;
      nz <= normal_z;
    end
    // An out-of-range read gives the empty answer without touching the store.
    if (state == ST_RD && op == OP_READ && !cur_en) begin
      res_count <= '0;
      res_empty <= 1'b1;
    end else if (state == ST_WR && op == OP_READ) begin
      res_count <= mem_rdata.count;
      res_empty <= (mem_rdata.count == '0);
    end
  end

  nva_store #(.DEPTH(DEPTH), .AW(AW)) u_store (
    .clk   (clk),
    .en    (mem_en),
    .we    (mem_we),
    .addr  (mem_addr),
    .wdata (mem_wdata),
    .rdata (mem_rdata)
  );

  nva_div_lane u_lane_x (
    .clk(clk), .rst(rst), .start(div_start), .dividend(mem_rdata.sum_x),
    .divisor(mem_rdata.count), .done(div_done_x), .quotient(qx)
  );

  nva_div_lane u_lane_y (
    .clk(clk), .rst(rst), .start(div_start), .dividend(mem_rdata.sum_y),
    .divisor(mem_rdata.count), .done(div_done_y), .quotient(qy)
  );

  nva_div_lane u_lane_z (
    .clk(clk), .rst(rst), .start(div_start), .dividend(mem_rdata.sum_z),
    .divisor(mem_rdata.count), .done(div_done_z), .quotient(qz)
  );

  assign info.vertex_id = va;
  assign info.count     = res_count;
  assign info.empty     = res_empty;

  nva_merge u_merge (
    .clk        (clk),
    .rst        (rst),
    .load       (merge_load),
    .info       (info),
    .qx         (qx),
    .qy         (qy),
    .qz         (qz),
    .ready      (merge_ready),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .vertex_id  (vertex_id),
    .avg_x      (avg_x),
    .avg_y      (avg_y),
    .avg_z      (avg_z),
    .face_count (face_count),
    .empty_res  (empty_res)
  );

`ifndef SYNTHESIS
  a_idle_no_write: assert property (@(posedge clk) disable iff (rst)
    (state == ST_IDLE) |-> !mem_we) else $error("store written while idle");
  a_lanes_agree: assert property (@(posedge clk) disable iff (rst)
    div_done_x |-> (div_done_y && div_done_z)) else $error("division lanes out of step");
  a_start_to_div: assert property (@(posedge clk) disable iff (rst)
    div_start |=> (state == ST_DIV)) else $error("division started outside a read");
  a_load_shows: assert property (@(posedge clk) disable iff (rst)
    (merge_load && merge_ready) |=> out_valid) else $error("result lost at merge");
  a_accept_busy: assert property (@(posedge clk) disable iff (rst)
    accept |=> in_stall) else $error("second beat taken while busy");
`endif

endmodule
